FILE: rtl/assert_macros.svh
// Assertion macros shared by the page replacer RTL.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BPPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true outside reset.
`define BPPR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/bppr_pkg.sv
// Package for the buffer pool page replacer: sizes, codes and shared types.
// Used by bppr_cell and buffer_pool_page_replacer_unit.
package bppr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int NCNT_BITS  = FRAME_BITS + 1;
  localparam int PAGE_BITS  = 24;
  localparam int STAMP_BITS = 32;
  localparam int FIX_BITS   = 8;
  localparam int COUNT_BITS = 32;
  localparam int CFG_BITS   = 5;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_PIN   = 3'd0,
    OP_UNPIN = 3'd1,
    OP_DIRTY = 3'd2,
    OP_FLUSH = 3'd3,
    OP_FORCE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_UNPIN_ERR  = 2'd1,
    STS_NO_VICTIM  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_POLICY = 1'b0,
    CFG_FRAMES = 1'b1
  } cfg_idx_e;

  // Replacement policies.
  localparam logic POLICY_FIFO = 1'b0;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_FIFO,
    S_LRU,
    S_EMIT,
    S_FLUSH
  } state_e;

  // Commands that a frame cell carries out.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_HIT,
    CMD_UNPIN,
    CMD_SET_DIRTY,
    CMD_CLR_DIRTY
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e             kind;
    logic [PAGE_BITS-1:0]  page;
    logic [STAMP_BITS-1:0] stamp;
  } cell_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
    logic [FIX_BITS-1:0]   fix;
    logic                  dirty;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic                  found;
    logic [FRAME_BITS-1:0] idx;
  } pick_t;

  // Lowest set bit of a frame vector.
  function automatic pick_t first_set(input logic [NUM_FRAMES-1:0] v);
    pick_t r;
    r = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = FRAME_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/bppr_cell.sv
// One frame of the pool: page, valid, fix count, dirty bit and LRU stamp.
// Depends on bppr_pkg for the entry and command types.
module bppr_cell
  import bppr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sel,
  input  cell_cmd_t cmd,
  output entry_t    entry
);

  // Apply the command when this frame is selected.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (sel) begin
      case (cmd.kind)
        CMD_LOAD: begin
          entry.valid <= 1'b1;
          entry.page  <= cmd.page;
          entry.fix   <= FIX_BITS'(1);
          entry.dirty <= 1'b0;
          entry.stamp <= cmd.stamp;
        end
        CMD_HIT: begin
          if (entry.fix != '1) begin
            entry.fix <= entry.fix + FIX_BITS'(1);
          end
          entry.stamp <= cmd.stamp;
        end
        CMD_UNPIN: begin
          if (entry.fix != '0) begin
            entry.fix <= entry.fix - FIX_BITS'(1);
          end
        end
        CMD_SET_DIRTY: entry.dirty <= 1'b1;
        CMD_CLR_DIRTY: entry.dirty <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/buffer_pool_page_replacer_unit.sv
// Buffer pool page replacer: a row of frame cells under one controller.
// Each item steps through S_IDLE (accept), S_LOOK (lookup) and S_EMIT (update, held while the output
// stalls), where the result loads into the output register; a pin miss under LRU adds the stamp sweep
// over the frames in use (S_LRU), a FIFO eviction adds S_FIFO, which first reduces a stale pointer, and
// flush all gives one writeback per cycle while the output is not stalled. No new item is taken before S_IDLE.
// Synchronous reset of all frames, counters, config, state and out_valid (not the data registers); no clearing pass.
`include "assert_macros.svh"

module buffer_pool_page_replacer_unit
  import bppr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            operation,
  input  logic [PAGE_BITS-1:0]  page_number,
  input  logic [FRAME_BITS-1:0] frame_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [FRAME_BITS-1:0] frame,
  output logic                  hit,
  output logic                  writeback_valid,
  output logic [PAGE_BITS-1:0]  writeback_page,
  output logic                  entry_valid,
  output logic [PAGE_BITS-1:0]  entry_page,
  output logic                  entry_dirty,
  output logic [FIX_BITS-1:0]   entry_fix_count,
  output logic [COUNT_BITS-1:0] read_count,
  output logic [COUNT_BITS-1:0] write_count,
  output logic                  last
);

  state_e                  state, state_next;
  logic                    policy;
  logic [CFG_BITS-1:0]     frames_cfg;
  logic [NCNT_BITS-1:0]    n_act;

  logic [2:0]              op_q;
  logic [PAGE_BITS-1:0]    page_q;
  logic [FRAME_BITS-1:0]   fidx_q;

  logic                    hit_q;
  logic [FRAME_BITS-1:0]   hit_idx_q;
  logic                    vic_found_q;
  logic                    vic_evict_q;
  logic [FRAME_BITS-1:0]   vic_idx_q;
  logic [STAMP_BITS-1:0]   best_stamp;
  logic [FRAME_BITS-1:0]   scan_idx;
  logic [FRAME_BITS-1:0]   ptr_s;

  logic [FRAME_BITS-1:0]   fifo_ptr, fifo_ptr_next;
  logic [STAMP_BITS-1:0]   stamp_cnt, stamp_next;
  logic [COUNT_BITS-1:0]   miss_cnt, miss_next;
  logic [COUNT_BITS-1:0]   write_cnt, write_next;

  entry_t                  entries [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]   cell_sel;
  cell_cmd_t               cell_cmd;

  logic [NUM_FRAMES-1:0]   active_mask, match_vec, empty_vec, unpinned_vec, qual_vec;
  logic [NUM_FRAMES-1:0]   from_scan, from_ptr, after_pick;
  pick_t                   match_pick, empty_pick, fifo_hi_pick, fifo_any_pick, flush_pick;
  entry_t                  scan_entry;
  logic                    slot_free;

  // Result fields before the output register.
  logic                    res_load;
  logic [1:0]              res_status;
  logic [FRAME_BITS-1:0]   res_frame;
  logic                    res_hit, res_wbv, res_last;
  logic [PAGE_BITS-1:0]    res_wbp;
  entry_t                  res_entry;

  // Row of frame cells.
  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    bppr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .sel   (cell_sel[g]),
      .cmd   (cell_cmd),
      .entry (entries[g])
    );
  end

  // Frames in use, clamped to the range one to NUM_FRAMES.
  always_comb begin
    if (frames_cfg == '0) begin
      n_act = NCNT_BITS'(1);
    end else if (frames_cfg > CFG_BITS'(NUM_FRAMES)) begin
      n_act = NCNT_BITS'(NUM_FRAMES);
    end else begin
      n_act = NCNT_BITS'(frames_cfg);
    end
  end

  // Per-frame flags, each from its own cell.
  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      active_mask[i]  = NCNT_BITS'(i) < n_act;
      match_vec[i]    = active_mask[i] && entries[i].valid && (entries[i].page == page_q);
      empty_vec[i]    = active_mask[i] && !entries[i].valid;
      unpinned_vec[i] = active_mask[i] && (entries[i].fix == '0);
      qual_vec[i]     = active_mask[i] && entries[i].valid && entries[i].dirty &&
                        (entries[i].fix == '0);
      from_scan[i]    = FRAME_BITS'(i) >= scan_idx;
      from_ptr[i]     = FRAME_BITS'(i) >= ptr_s;
    end
  end

  assign match_pick    = first_set(match_vec);
  assign empty_pick    = first_set(empty_vec);
  assign fifo_hi_pick  = first_set(unpinned_vec & from_ptr);
  assign fifo_any_pick = first_set(unpinned_vec);
  assign flush_pick    = first_set(qual_vec & from_scan);
  assign scan_entry    = entries[scan_idx];

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      after_pick[i] = FRAME_BITS'(i) > flush_pick.idx;
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // Next state, result and cell commands.
  always_comb begin
    state_next     = state;
    cell_sel       = '0;
    cell_cmd.kind  = CMD_NONE;
    cell_cmd.page  = page_q;
    cell_cmd.stamp = stamp_cnt;
    res_load       = 1'b0;
    res_status     = STS_OK;
    res_frame      = '0;
    res_hit        = 1'b0;
    res_wbv        = 1'b0;
    res_wbp        = '0;
    res_entry      = '0;
    res_last       = 1'b1;
    miss_next      = miss_cnt;
    write_next     = write_cnt;
    stamp_next     = stamp_cnt;
    fifo_ptr_next  = fifo_ptr;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_q == OP_FLUSH) begin
          state_next = S_FLUSH;
        end else if (op_q == OP_PIN && !match_pick.found && !empty_pick.found) begin
          state_next = (policy == POLICY_FIFO) ? S_FIFO : S_LRU;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FIFO: begin
        if (NCNT_BITS'(ptr_s) < n_act) begin
          state_next = S_EMIT;
        end
      end
      S_LRU: begin
        if (NCNT_BITS'(scan_idx) == n_act - NCNT_BITS'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_PIN: begin
              if (hit_q) begin
                cell_sel[hit_idx_q] = 1'b1;
                cell_cmd.kind       = CMD_HIT;
                stamp_next          = stamp_cnt + STAMP_BITS'(1);
                res_frame           = hit_idx_q;
                res_hit             = 1'b1;
              end else if (vic_found_q) begin
                cell_sel[vic_idx_q] = 1'b1;
                cell_cmd.kind       = CMD_LOAD;
                stamp_next          = stamp_cnt + STAMP_BITS'(1);
                miss_next           = miss_cnt + COUNT_BITS'(1);
                res_frame           = vic_idx_q;
                if (vic_evict_q && entries[vic_idx_q].dirty) begin
                  res_wbv    = 1'b1;
                  res_wbp    = entries[vic_idx_q].page;
                  write_next = write_cnt + COUNT_BITS'(1);
                end
                if (vic_evict_q && policy == POLICY_FIFO) begin
                  if (NCNT_BITS'(vic_idx_q) + NCNT_BITS'(1) == n_act) begin
                    fifo_ptr_next = '0;
                  end else begin
                    fifo_ptr_next = vic_idx_q + FRAME_BITS'(1);
                  end
                end
              end else begin
                res_status = STS_NO_VICTIM;
              end
            end
            OP_UNPIN: begin
              if (hit_q) begin
                if (entries[hit_idx_q].fix != '0) begin
                  cell_sel[hit_idx_q] = 1'b1;
                  cell_cmd.kind       = CMD_UNPIN;
                end else begin
                  res_status = STS_UNPIN_ERR;
                end
              end
            end
            OP_DIRTY: begin
              if (hit_q) begin
                cell_sel[hit_idx_q] = 1'b1;
                cell_cmd.kind       = CMD_SET_DIRTY;
              end
            end
            OP_FORCE: begin
              if (hit_q) begin
                cell_sel[hit_idx_q] = 1'b1;
                cell_cmd.kind       = CMD_CLR_DIRTY;
              end
              res_wbv    = 1'b1;
              res_wbp    = page_q;
              write_next = write_cnt + COUNT_BITS'(1);
            end
            OP_READ: begin
              res_entry       = entries[fidx_q];
              res_entry.stamp = '0;
            end
            default: ;
          endcase
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (!flush_pick.found) begin
            state_next = S_IDLE;
          end else begin
            cell_sel[flush_pick.idx] = 1'b1;
            cell_cmd.kind            = CMD_CLR_DIRTY;
            res_wbv                  = 1'b1;
            res_wbp                  = entries[flush_pick.idx].page;
            write_next               = write_cnt + COUNT_BITS'(1);
            res_last                 = ((qual_vec & after_pick) == '0);
            if (res_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POLICY_FIFO;
      frames_cfg <= CFG_BITS'(NUM_FRAMES);
      fifo_ptr   <= '0;
      stamp_cnt  <= '0;
      miss_cnt   <= '0;
      write_cnt  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_POLICY: policy     <= cfg_data[0];
          CFG_FRAMES: frames_cfg <= cfg_data;
          default: ;
        endcase
      end
      fifo_ptr  <= fifo_ptr_next;
      stamp_cnt <= stamp_next;
      miss_cnt  <= miss_next;
      write_cnt <= write_next;
    end
  end

  // Item registers, lookup results and the victim searches.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q   <= operation;
          page_q <= page_number;
          fidx_q <= frame_index;
        end
      end
      S_LOOK: begin
        hit_q       <= match_pick.found;
        hit_idx_q   <= match_pick.idx;
        vic_found_q <= empty_pick.found;
        vic_idx_q   <= empty_pick.idx;
        vic_evict_q <= !empty_pick.found;
        scan_idx    <= '0;
        ptr_s       <= fifo_ptr;
      end
      S_FIFO: begin
        // Reduce a pointer left over from a larger pool, then scan with wrap.
        if (NCNT_BITS'(ptr_s) >= n_act) begin
          ptr_s <= ptr_s - n_act[FRAME_BITS-1:0];
        end else if (fifo_hi_pick.found) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= fifo_hi_pick.idx;
        end else begin
          vic_found_q <= fifo_any_pick.found;
          vic_idx_q   <= fifo_any_pick.idx;
        end
      end
      S_LRU: begin
        // One frame a cycle; the least stamp wins, the lower frame on a tie.
        if (unpinned_vec[scan_idx] && (!vic_found_q || scan_entry.stamp < best_stamp)) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= scan_idx;
          best_stamp  <= scan_entry.stamp;
        end
        scan_idx <= scan_idx + FRAME_BITS'(1);
      end
      S_FLUSH: begin
        if (slot_free && flush_pick.found) begin
          scan_idx <= flush_pick.idx + FRAME_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register; a new result loads when the slot is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status          <= res_status;
      frame           <= res_frame;
      hit             <= res_hit;
      writeback_valid <= res_wbv;
      writeback_page  <= res_wbp;
      entry_valid     <= res_entry.valid;
      entry_page      <= res_entry.page;
      entry_dirty     <= res_entry.dirty;
      entry_fix_count <= res_entry.fix;
      read_count      <= miss_next;
      write_count     <= write_next;
      last            <= res_last;
    end
  end

  // An evicted frame must be unpinned and inside the pool.
  `BPPR_ASSERT(a_victim_unpinned, (state == S_EMIT && op_q == OP_PIN && !hit_q && vic_found_q && vic_evict_q) |-> (entries[vic_idx_q].fix == '0), "evicted frame is pinned")
  `BPPR_ASSERT_NEVER(a_victim_active, state == S_EMIT && op_q == OP_PIN && vic_found_q && NCNT_BITS'(vic_idx_q) >= n_act, "victim outside the frames in use")
  `BPPR_ASSERT(a_write_step, !$past(rst) |-> ((write_cnt == $past(write_cnt)) || (write_cnt == $past(write_cnt) + COUNT_BITS'(1))), "writeback count moved by more than one")

endmodule

FILE: bench/buffer_pool_page_replacer_unit_tb.sv
// Self-checking testbench for buffer_pool_page_replacer_unit: pin, unpin, dirty, flush, force, read.
// Depends on bppr_pkg and the unit RTL; predicts every result and compares all of its fields at once.
`timescale 1ns / 1ps

module buffer_pool_page_replacer_unit_tb;
  import bppr_pkg::*;

  typedef struct packed {
    logic [2:0]            op;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] fidx;
  } request_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
    logic                  wb_valid;
    logic [PAGE_BITS-1:0]  wb_page;
    logic                  e_valid;
    logic [PAGE_BITS-1:0]  e_page;
    logic                  e_dirty;
    logic [FIX_BITS-1:0]   e_fix;
    logic [COUNT_BITS-1:0] reads;
    logic [COUNT_BITS-1:0] writes;
    logic                  last;
  } reply_t;

  localparam int LIMIT = 400000;

  logic clk, rst;
  logic cfg_write, cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] operation;
  logic [PAGE_BITS-1:0] page_number;
  logic [FRAME_BITS-1:0] frame_index;
  logic [1:0] status;
  logic [FRAME_BITS-1:0] frame;
  logic hit, writeback_valid, entry_valid, entry_dirty, last;
  logic [PAGE_BITS-1:0] writeback_page, entry_page;
  logic [FIX_BITS-1:0] entry_fix_count;
  logic [COUNT_BITS-1:0] read_count, write_count;

  buffer_pool_page_replacer_unit i_dut (.*);

  // Shadow copy of the frame table.
  logic                  sh_valid [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  sh_page  [NUM_FRAMES];
  logic [FIX_BITS-1:0]   sh_fix   [NUM_FRAMES];
  logic                  sh_dirty [NUM_FRAMES];
  logic [STAMP_BITS-1:0] sh_stamp [NUM_FRAMES];
  logic [FRAME_BITS-1:0] sh_fifo;
  logic [STAMP_BITS-1:0] sh_clock;
  logic [COUNT_BITS-1:0] sh_misses, sh_wbs;
  logic                  sh_policy;
  logic [4:0]            sh_frames;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int errors, cycles, sent, received, stall_hold, gap_hold, flushes;
  logic quiet, hold_sender;

  function automatic reply_t blank_reply();
    reply_t r;
    r = '0;
    r.reads  = sh_misses;
    r.writes = sh_wbs;
    return r;
  endfunction

  // Apply one request to the shadow table and queue the results it causes.
  task automatic predict_request(input request_t rq);
    int n, f, v, s, c, k;
    reply_t r;
    n = (sh_frames == 0) ? 1 : (sh_frames > NUM_FRAMES ? NUM_FRAMES : sh_frames);
    f = -1;
    for (int i = n - 1; i >= 0; i--)
      if (sh_valid[i] && sh_page[i] == rq.page) f = i;
    k = 0;
    case (rq.op)
      OP_PIN: begin
        r = blank_reply();
        if (f >= 0) begin
          if (sh_fix[f] < 255) sh_fix[f]++;
          sh_stamp[f] = sh_clock;
          sh_clock++;
          r.frame = FRAME_BITS'(f);
          r.hit = 1'b1;
        end else begin
          v = -1;
          for (int i = n - 1; i >= 0; i--)
            if (!sh_valid[i]) v = i;
          if (v < 0) begin
            if (sh_policy == POLICY_FIFO) begin
              s = sh_fifo % n;
              for (int i = 0; i < n; i++) begin
                c = (s + i) % n;
                if (v < 0 && sh_fix[c] == 0) v = c;
              end
              if (v >= 0) sh_fifo = FRAME_BITS'((v + 1) % n);
            end else begin
              for (int i = 0; i < n; i++)
                if (sh_fix[i] == 0 && (v < 0 || sh_stamp[i] < sh_stamp[v])) v = i;
            end
            if (v >= 0 && sh_dirty[v]) begin
              r.wb_valid = 1'b1;
              r.wb_page = sh_page[v];
              sh_wbs++;
            end
          end
          if (v < 0) begin
            r.status = STS_NO_VICTIM;
          end else begin
            sh_valid[v] = 1'b1;
            sh_page[v] = rq.page;
            sh_fix[v] = FIX_BITS'(1);
            sh_dirty[v] = 1'b0;
            sh_stamp[v] = sh_clock;
            sh_clock++;
            sh_misses++;
            r.frame = FRAME_BITS'(v);
          end
          r.reads = sh_misses;
          r.writes = sh_wbs;
        end
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      OP_UNPIN: begin
        r = blank_reply();
        if (f >= 0) begin
          if (sh_fix[f] > 0) sh_fix[f]--;
          else r.status = STS_UNPIN_ERR;
        end
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      OP_DIRTY: begin
        if (f >= 0) sh_dirty[f] = 1'b1;
        r = blank_reply();
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      OP_FLUSH: begin
        for (int i = 0; i < n; i++) begin
          if (sh_valid[i] && sh_dirty[i] && sh_fix[i] == 0) begin
            sh_dirty[i] = 1'b0;
            sh_wbs++;
            r = blank_reply();
            r.wb_valid = 1'b1;
            r.wb_page = sh_page[i];
            expected_replies.push_back(r);
            k++;
          end
        end
        if (k == 0) expected_replies.push_back(blank_reply());
        r = expected_replies.pop_back();
        r.last = 1'b1;
        expected_replies.push_back(r);
        flushes++;
      end
      OP_FORCE: begin
        if (f >= 0) sh_dirty[f] = 1'b0;
        sh_wbs++;
        r = blank_reply();
        r.wb_valid = 1'b1;
        r.wb_page = rq.page;
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      OP_READ: begin
        r = blank_reply();
        r.e_valid = sh_valid[rq.fidx];
        r.e_page = sh_page[rq.fidx];
        r.e_dirty = sh_dirty[rq.fidx];
        r.e_fix = sh_fix[rq.fidx];
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      default: begin
        r = blank_reply();
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
    endcase
  endtask

  // Clock source.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter with a generous limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender: offer queued items; a transfer updates the shadow table.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_hold <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(pending_reqs.pop_front());
        sent <= sent + 1;
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (gap_hold > 0) begin
          gap_hold <= gap_hold - 1;
          in_valid <= 1'b0;
        end else if (!quiet && !hold_sender && $urandom_range(0, 9) == 0) begin
          gap_hold <= $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else if (!hold_sender && pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          {operation, page_number, frame_index} <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in bursts, check each transfer against the oldest expectation.
  always @(posedge clk) begin
    reply_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, frame, hit, writeback_valid, writeback_page, entry_valid, entry_page,
                entry_dirty, entry_fix_count, read_count, write_count, last};
        received <= received + 1;
        if (expected_replies.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            $display("%0t mismatch: expected %p actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_hold <= $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_req(input op_e op, input int pg, input int fi = 0);
    request_t rq;
    rq.op = op;
    rq.page = PAGE_BITS'(pg);
    rq.fidx = FRAME_BITS'(fi);
    pending_reqs.push_back(rq);
  endtask

  task automatic add_raw(input logic [2:0] op, input logic [PAGE_BITS-1:0] pg,
                         input logic [FRAME_BITS-1:0] fi);
    request_t rq;
    rq.op = op;
    rq.page = pg;
    rq.fidx = fi;
    pending_reqs.push_back(rq);
  endtask

  // Wait until every item is sent and every result has come, then settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_POLICY) sh_policy = value[0];
    else sh_frames = CFG_BITS'(value);
  endtask

  // Random phase: a small page set so hits, evictions and errors are frequent.
  task automatic random_phase(input int count, input int pages);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       add_raw(3'($urandom_range(0, 7)), PAGE_BITS'($urandom),
                                  FRAME_BITS'($urandom));
      else if (pick < 40) add_req(OP_PIN, $urandom_range(0, pages - 1));
      else if (pick < 65) add_req(OP_UNPIN, $urandom_range(0, pages - 1));
      else if (pick < 77) add_req(OP_DIRTY, $urandom_range(0, pages - 1));
      else if (pick < 82) add_req(OP_FLUSH, 0);
      else if (pick < 87) add_req(OP_FORCE, $urandom_range(0, pages));
      else                add_req(OP_READ, 0, $urandom_range(0, 15));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    operation = '0;
    page_number = '0;
    frame_index = '0;
    errors = 0; cycles = 0; sent = 0; received = 0; flushes = 0;
    stall_hold = 0; gap_hold = 0;
    quiet = 1'b0;
    hold_sender = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      sh_valid[i] = 0; sh_page[i] = 0; sh_fix[i] = 0; sh_dirty[i] = 0; sh_stamp[i] = 0;
    end
    sh_fifo = 0; sh_clock = 0; sh_misses = 0; sh_wbs = 0;
    sh_policy = POLICY_FIFO;
    sh_frames = 16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme pages, every operation, unknown codes, a full pool with no victim.
    write_reg(CFG_FRAMES, 2);
    add_req(OP_PIN, 24'hFFFFFF);
    add_req(OP_PIN, 0);
    add_req(OP_PIN, 24'hFFFFFF);
    add_req(OP_PIN, 5);
    add_req(OP_UNPIN, 0);
    add_req(OP_UNPIN, 0);
    add_req(OP_UNPIN, 77);
    add_req(OP_DIRTY, 0);
    add_req(OP_DIRTY, 99);
    add_req(OP_READ, 0, 1);
    add_req(OP_READ, 0, 15);
    add_req(OP_PIN, 6);
    add_req(OP_UNPIN, 24'hFFFFFF);
    add_req(OP_UNPIN, 24'hFFFFFF);
    add_req(OP_DIRTY, 24'hFFFFFF);
    add_req(OP_DIRTY, 6);
    add_req(OP_FLUSH, 0);
    add_req(OP_FLUSH, 0);
    add_req(OP_FORCE, 6);
    add_req(OP_FORCE, 24'hABCDEF);
    add_raw(3'd6, 24'h123456, 4'hF);
    add_raw(3'd7, 24'hFFFFFF, 4'h0);
    add_req(OP_READ, 0, 0);
    drain();

    // Frame count of zero acts as one; sixteen is the full pool.
    write_reg(CFG_FRAMES, 0);
    random_phase(30, 4);
    drain();

    // Receiver holds off for a long stretch while the sender keeps offering.
    write_reg(CFG_POLICY, 1);
    write_reg(CFG_FRAMES, 16);
    random_phase(60, 24);
    stall_hold = 300;
    drain();

    // Sender pauses until every result has come.
    write_reg(CFG_FRAMES, 5);
    random_phase(60, 9);
    hold_sender = 1'b1;
    while (expected_replies.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    random_phase(30, 9);
    drain();

    write_reg(CFG_POLICY, 0);
    write_reg(CFG_FRAMES, 31);
    random_phase(120, 22);
    drain();

    write_reg(CFG_FRAMES, 8);
    random_phase(100, 12);
    drain();

    // Last part runs without any idling.
    quiet = 1'b1;
    write_reg(CFG_POLICY, 1);
    write_reg(CFG_FRAMES, 3);
    random_phase(60, 6);
    drain();

    $display("Covered %0d items and %0d results, %0d flushes, both policies, 1 to 16 frames.",
             sent, received, flushes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bppr_pkg.sv
rtl/bppr_cell.sv
rtl/buffer_pool_page_replacer_unit.sv
bench/buffer_pool_page_replacer_unit_tb.sv
